FILE: rtl/core/assert_macros.svh
// assertion macros for the p50 command decoder
// each macro samples on clk and is disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define P50_ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true outside reset
`define P50_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

FILE: rtl/core/p50cd_pkg.sv
// shared types and constants for the p50 command decoder
// no dependencies
package p50cd_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned ModuleW = 6;
	localparam int unsigned TdataW  = 32;

	typedef enum logic [2:0] {
		KIND_POWER_ON  = 3'd0,
		KIND_POWER_OFF = 3'd1,
		KIND_COIL_OFF  = 3'd2,
		KIND_SWITCH    = 3'd3,
		KIND_LOCO      = 3'd4,
		KIND_FUNCS     = 3'd5,
		KIND_QUERY     = 3'd6
	} kind_t;

	localparam logic [ByteW-1:0] OP_COIL_OFF  = 8'd32;
	localparam logic [ByteW-1:0] OP_SWITCH_B  = 8'd33;
	localparam logic [ByteW-1:0] OP_SWITCH_A  = 8'd34;
	localparam logic [ByteW-1:0] OP_LOCO_MAX  = 8'd31;
	localparam logic [ByteW-1:0] OP_FUNC_MIN  = 8'd64;
	localparam logic [ByteW-1:0] OP_FUNC_MAX  = 8'd79;
	localparam logic [ByteW-1:0] OP_POWER_ON  = 8'd96;
	localparam logic [ByteW-1:0] OP_POWER_OFF = 8'd97;
	localparam logic [ByteW-1:0] OP_MULTI_MIN = 8'd129;
	localparam logic [ByteW-1:0] OP_MULTI_MAX = 8'd192;
	localparam logic [3:0]       SPEED_REV    = 4'd15;

	typedef enum logic {
		ST_IDLE  = 1'b0,
		ST_BURST = 1'b1
	} state_t;

	typedef struct packed {
		kind_t               kind;
		logic [7:0]          target;
		logic [2:0]          coil;
		logic                coil_on;
		logic [3:0]          speed_step;
		logic                reverse;
		logic                light;
		logic [3:0]          func_bits;
		logic [ModuleW-1:0]  module_res;
		logic                last;
	} result_t;

	typedef struct packed {
		logic load;
		logic step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic opens_burst;
		logic burst_last;
	} dp_status_t;

endpackage

FILE: rtl/core/p50cd_ctrl.sv
// controller state machine for the p50 command decoder
// depends on p50cd_pkg
module p50cd_ctrl import p50cd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load && status.opens_burst) begin
					state_d = ST_BURST;
				end
			end
			ST_BURST: begin
				if (cmd.step && status.burst_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = status.slot_free;
				cmd.load = in_valid && status.slot_free;
			end
			ST_BURST: begin
				cmd.step = status.slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/core/p50cd_datapath.sv
// decode datapath, protocol state and output register of the p50 command decoder
// depends on p50cd_pkg and assert_macros.svh
`include "assert_macros.svh"

module p50cd_datapath import p50cd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_cmd_t        cmd,
	output dp_status_t       status,
	input  logic [ByteW-1:0] rx_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output result_t          out_res
);

	logic [ByteW-1:0]   pending_first_q;
	logic               awaiting_q;
	logic [6:0]         last_switch_q;
	logic [ModuleW-1:0] cnt_q;
	logic [ModuleW-1:0] last_idx_q;
	logic               out_valid_q;
	result_t            out_res_q;

	result_t            dec_res;
	result_t            step_res;
	logic               dec_has;
	logic               dec_opener;
	logic               dec_sw_upd;
	logic [6:0]         dec_sw;
	logic [ByteW-1:0]   a1;
	logic [3:0]         spd;
	logic               is_multi;
	logic [ByteW-1:0]   multi_idx;

	assign a1        = rx_byte - 8'd1;
	assign spd       = pending_first_q[3:0];
	assign is_multi  = (rx_byte >= OP_MULTI_MIN) && (rx_byte <= OP_MULTI_MAX);
	assign multi_idx = rx_byte - OP_MULTI_MIN;
	assign dec_sw    = {1'b0, a1[7:2]} + 7'd1;

	always_comb begin
		dec_res    = '0;
		dec_has    = 1'b0;
		dec_opener = 1'b0;
		dec_sw_upd = 1'b0;
		dec_res.last = 1'b1;
		if (awaiting_q) begin
			// second byte is always the address
			if (pending_first_q == OP_SWITCH_B || pending_first_q == OP_SWITCH_A) begin
				if (rx_byte != '0) begin
					dec_has            = 1'b1;
					dec_sw_upd         = 1'b1;
					dec_res.kind       = KIND_SWITCH;
					dec_res.target     = {1'b0, dec_sw};
					dec_res.coil       = {a1[1:0], pending_first_q[0]};
					dec_res.coil_on    = 1'b1;
				end
			end else if (pending_first_q <= OP_LOCO_MAX) begin
				dec_has            = 1'b1;
				dec_res.kind       = KIND_LOCO;
				dec_res.target     = rx_byte;
				dec_res.reverse    = (spd == SPEED_REV);
				dec_res.speed_step = (spd == SPEED_REV) ? 4'd0 : spd;
				dec_res.light      = pending_first_q[4];
			end else if (pending_first_q >= OP_FUNC_MIN && pending_first_q <= OP_FUNC_MAX) begin
				dec_has           = 1'b1;
				dec_res.kind      = KIND_FUNCS;
				dec_res.target    = rx_byte;
				dec_res.func_bits = pending_first_q[3:0];
			end
		end else if (rx_byte == OP_POWER_ON) begin
			dec_has      = 1'b1;
			dec_res.kind = KIND_POWER_ON;
		end else if (rx_byte == OP_POWER_OFF) begin
			dec_has      = 1'b1;
			dec_res.kind = KIND_POWER_OFF;
		end else if (rx_byte == OP_COIL_OFF) begin
			dec_has        = 1'b1;
			dec_res.kind   = KIND_COIL_OFF;
			dec_res.target = {1'b0, last_switch_q};
		end else if (is_multi) begin
			// first query of a burst, module 0
			dec_has      = 1'b1;
			dec_res.kind = KIND_QUERY;
			dec_res.last = (rx_byte == OP_MULTI_MIN);
		end else if (rx_byte > OP_MULTI_MAX) begin
			dec_has            = 1'b1;
			dec_res.kind       = KIND_QUERY;
			dec_res.module_res = rx_byte[ModuleW-1:0];
		end else if (rx_byte == OP_SWITCH_B || rx_byte == OP_SWITCH_A
				|| rx_byte <= OP_LOCO_MAX
				|| (rx_byte >= OP_FUNC_MIN && rx_byte <= OP_FUNC_MAX)) begin
			dec_opener = 1'b1;
		end
	end

	// next query item of a running burst
	always_comb begin
		step_res            = '0;
		step_res.kind       = KIND_QUERY;
		step_res.module_res = cnt_q;
		step_res.last       = (cnt_q == last_idx_q);
	end

	assign status.slot_free   = !out_valid_q || out_ready;
	assign status.opens_burst = !awaiting_q && is_multi && (rx_byte != OP_MULTI_MIN);
	assign status.burst_last  = (cnt_q == last_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_first_q <= '0;
			awaiting_q      <= 1'b0;
			last_switch_q   <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (awaiting_q) begin
					awaiting_q <= 1'b0;
				end else if (dec_opener) begin
					awaiting_q      <= 1'b1;
					pending_first_q <= rx_byte;
				end
				if (dec_sw_upd) begin
					last_switch_q <= dec_sw;
				end
			end
			if ((cmd.load && dec_has) || cmd.step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// burst counter and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cnt_q      <= ModuleW'(1);
			last_idx_q <= multi_idx[ModuleW-1:0];
			if (dec_has) begin
				out_res_q <= dec_res;
			end
		end else if (cmd.step) begin
			cnt_q     <= cnt_q + ModuleW'(1);
			out_res_q <= step_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	`P50_ASSERT_PROP(a_out_hold, out_valid_q && !out_ready |=> out_valid_q && $stable(out_res_q), "result changed while stalled")
	`P50_ASSERT_NEVER(a_burst_range, cmd.step && (cnt_q > last_idx_q), "burst counter past final module")
	`P50_ASSERT_PROP(a_addr_taken, cmd.load && awaiting_q |=> !awaiting_q, "address byte not consumed")

endmodule

FILE: rtl/core/p50_command_decoder_top.sv
// top level of the p50 command decoder: stream ports, controller and datapath
// depends on p50cd_pkg, p50cd_ctrl and p50cd_datapath
//
// Decodes bytes of the P50 railway interface into command items. A switch, loco drive
// or loco function opener is stored and completed by the next byte. A multi-module
// query byte (129 to 192) yields n = byte - 128 query items, one per cycle from the
// output register while m_tready is high, so it holds s_tready low while the burst
// counter runs. A result waiting in the output register blocks input only while
// m_tready is low; unused bytes and switch address zero give no item.
module p50_command_decoder_top import p50cd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [ByteW-1:0]  s_tdata,   // [7:0] rx_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [TdataW-1:0] m_tdata,   // [2:0] kind, [10:3] target, [13:11] coil,
	                                     // [14] coil_on, [18:15] speed_step, [19] reverse,
	                                     // [20] light, [24:21] func_bits, [30:25] module_res,
	                                     // [31] zero
	output logic              m_tlast
);

	ctrl_cmd_t  cmd;
	dp_status_t status;
	result_t    res;

	p50cd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	p50cd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.rx_byte   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {1'b0, res.module_res, res.func_bits, res.light, res.reverse,
			res.speed_step, res.coil_on, res.coil, res.target, res.kind};
	assign m_tlast = res.last;

endmodule
